[rtl/core/vrt_pkg.sv]
// Shared types and constants for the voxel ray traversal block.
// No dependencies; imported by the iterative unit and the top level.
`default_nettype none

package vrt_pkg;

	localparam int T_FRAC_BITS_DEF     = 16;
	localparam int COORD_FRAC_BITS_DEF = 16;

	localparam logic [7:0]  GRID_EXTENT_RST = 8'd160;
	localparam logic [31:0] ALL_ONES32      = 32'hFFFF_FFFF;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam logic [1:0] STEP_POS  = 2'b01;
	localparam logic [1:0] STEP_NEG  = 2'b11;
	localparam logic [1:0] STEP_NONE = 2'b00;

	typedef enum logic {
		UNIT_DIV  = 1'b0,
		UNIT_SQRT = 1'b1
	} unit_mode_t;

	typedef struct packed {
		logic       start;
		unit_mode_t mode;
	} vrt_unit_req_t;

endpackage

`default_nettype wire

[rtl/core/vrt_iter_unit.sv]
// Iterative restoring divide and square root unit sharing one subtractor.
// Depends on vrt_pkg for the request struct and mode codes.
`default_nettype none

module vrt_iter_unit
	import vrt_pkg::*;
#(
	parameter int NUM_W = T_FRAC_BITS_DEF + 25
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vrt_unit_req_t      req,
	input  wire logic [NUM_W-1:0]   num,
	input  wire logic [31:0]        den,
	output logic                    done,
	output logic [31:0]             result
);

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);

	logic             busy_q;
	logic             done_q;
	unit_mode_t       mode_q;
	logic [NUM_W-1:0] sr_q;
	logic [NUM_W-1:0] quo_q;
	logic [33:0]      rem_q;
	logic [31:0]      den_q;
	logic [CNT_W-1:0] cnt_q;

	logic [35:0] op_a;
	logic [35:0] op_b;
	logic [36:0] diff;
	logic        ge;

	always_comb begin
		if (mode_q == UNIT_SQRT) begin
			op_a = {rem_q, sr_q[NUM_W-1 -: 2]};
			op_b = {2'b00, quo_q[31:0], 2'b01};
		end else begin
			op_a = {3'b000, rem_q[31:0], sr_q[NUM_W-1]};
			op_b = {4'b0000, den_q};
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = !diff[36];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= UNIT_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					mode_q <= req.mode;
					cnt_q  <= '0;
					den_q  <= den;
					rem_q  <= '0;
					quo_q  <= '0;
					if (req.mode == UNIT_SQRT) begin
						sr_q <= {num[31:0], {(NUM_W-32){1'b0}}};
					end else begin
						sr_q <= num;
					end
				end
			end else begin
				if (mode_q == UNIT_SQRT) begin
					sr_q  <= sr_q << 2;
					rem_q <= ge ? diff[33:0] : op_a[33:0];
				end else begin
					sr_q  <= sr_q << 1;
					rem_q <= ge ? diff[33:0] : op_a[33:0];
				end
				quo_q <= {quo_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if ((mode_q == UNIT_SQRT && cnt_q == SQRT_LAST) ||
				    (mode_q == UNIT_DIV && cnt_q == DIV_LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotients wider than 32 bits saturate; a zero divisor gives all ones.
	always_comb begin
		if (mode_q == UNIT_DIV && (|quo_q[NUM_W-1:32])) begin
			result = ALL_ONES32;
		end else begin
			result = quo_q[31:0];
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

[rtl/core/voxel_ray_traversal.sv]
// Voxel ray traversal top level: sequencer, ray state and stream ports.
// Depends on vrt_pkg and vrt_iter_unit (shared divide / square root unit).
// Start word: the result follows the seven divisions and one 32-step square root run in the
// shared unit after acceptance; ready returns in the same cycle as the result.
// Advance word: a new word is accepted only after the previous result is registered; a held result stalls input.
// Reset (arst_n low, asynchronous) clears the ray state and sets grid_extent to 160.
`default_nettype none

module voxel_ray_traversal
	import vrt_pkg::*;
#(
	parameter int T_FRAC_BITS     = T_FRAC_BITS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [7:0]   cfg_wr_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_length, zero fill
	input  wire logic [143:0] s_tdata,
	// command
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// voxel_x, voxel_y, voxel_z, face_x, face_y, face_z, inside_res, done_res,
	// no_direction, zero fill
	output logic [39:0]       m_tdata
);

	localparam int NUM_W = T_FRAC_BITS + 25;
	localparam int XW    = COORD_FRAC_BITS + T_FRAC_BITS + 1;
	localparam logic [NUM_W-1:0] SP_NUM = NUM_W'(1) << T_FRAC_BITS;
	localparam logic [COORD_FRAC_BITS:0] ONE_C = (COORD_FRAC_BITS+1)'(1) << COORD_FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_OP_START,
		ST_OP_WAIT,
		ST_ADV1,
		ST_ADV2,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [7:0]  extent_q;
	logic [8:0]  pos_q   [3];
	logic [1:0]  sign_q  [3];
	logic [31:0] nc_q    [3];
	logic [31:0] sp_q    [3];
	logic [1:0]  face_q  [3];
	logic [15:0] mag_q   [3];
	logic [NUM_W-1:0] ncnum_q [3];
	logic [16:0] len_q;
	logic [31:0] sumsq_q;
	logic [31:0] mq16_q;
	logic [31:0] limit_q;
	logic        active_q;
	logic        nodir_q;
	logic [1:0]  sq_idx_q;
	logic [2:0]  op_q;
	logic [1:0]  ax_q;
	logic        out_valid_q;
	logic [39:0] out_data_q;

	// Input field unpacking and start-word per-axis setup.
	logic signed [24:0] org  [3];
	logic signed [15:0] dirc [3];
	logic [8:0]         st_pos   [3];
	logic [1:0]         st_sign  [3];
	logic [15:0]        st_mag   [3];
	logic [NUM_W-1:0]   st_ncnum [3];

	always_comb begin
		logic signed [24:0]       osh;
		logic [COORD_FRAC_BITS-1:0] frac;
		logic [COORD_FRAC_BITS:0]   first_dist;
		logic [XW-1:0]            xnum;
		org[0]  = s_tdata[24:0];
		org[1]  = s_tdata[49:25];
		org[2]  = s_tdata[74:50];
		dirc[0] = s_tdata[90:75];
		dirc[1] = s_tdata[106:91];
		dirc[2] = s_tdata[122:107];
		for (int a = 0; a < 3; a++) begin
			osh       = org[a] >>> COORD_FRAC_BITS;
			st_pos[a] = osh[8:0];
			st_mag[a] = dirc[a][15] ? 16'(-dirc[a]) : dirc[a];
			frac      = org[a][COORD_FRAC_BITS-1:0];
			if (dirc[a] == 16'sd0) begin
				st_sign[a] = STEP_NONE;
			end else if (dirc[a][15]) begin
				st_sign[a] = STEP_NEG;
			end else begin
				st_sign[a] = STEP_POS;
			end
			if (st_sign[a] == STEP_POS) begin
				first_dist = ONE_C - {1'b0, frac};
			end else if (frac != '0) begin
				first_dist = {1'b0, frac};
			end else begin
				first_dist = ONE_C;
			end
			xnum        = XW'(first_dist) << T_FRAC_BITS;
			st_ncnum[a] = NUM_W'(xnum >> COORD_FRAC_BITS);
		end
	end

	function automatic logic axis_cont(logic [8:0] p, logic [1:0] s, logic [7:0] ext);
		if (s == STEP_POS) begin
			return p[8] || (p[7:0] < ext);
		end
		return !p[8];
	endfunction

	logic cont;
	logic in_grid;
	always_comb begin
		cont    = 1'b1;
		in_grid = 1'b1;
		for (int a = 0; a < 3; a++) begin
			cont    = cont && axis_cont(pos_q[a], sign_q[a], extent_q);
			in_grid = in_grid && !pos_q[a][8] && (pos_q[a][7:0] < extent_q);
		end
	end

	// Shared unit operand selection.
	vrt_unit_req_t    unit_req;
	logic [NUM_W-1:0] unit_num;
	logic [31:0]      unit_den;
	logic             unit_done;
	logic [31:0]      unit_res;

	always_comb begin
		unit_req.start = (state_q == ST_OP_START);
		unit_req.mode  = (op_q == 3'd6) ? UNIT_SQRT : UNIT_DIV;
		unit_num       = '0;
		unit_den       = '0;
		case (op_q)
			3'd6: begin
				unit_num = NUM_W'(sumsq_q);
			end
			3'd7: begin
				unit_num = NUM_W'(len_q) << (T_FRAC_BITS + 8);
				unit_den = mq16_q;
			end
			default: begin
				unit_num = op_q[0] ? ncnum_q[op_q[2:1]] : SP_NUM;
				unit_den = {16'b0, mag_q[op_q[2:1]]};
			end
		endcase
	end

	vrt_iter_unit #(
		.NUM_W(NUM_W)
	) u_iter (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (unit_req),
		.num   (unit_num),
		.den   (unit_den),
		.done  (unit_done),
		.result(unit_res)
	);

	// Axis with the smallest next crossing; ties go to the later axis.
	logic [1:0] sel_ax;
	always_comb begin
		if (nc_q[0] < nc_q[1]) begin
			sel_ax = (nc_q[0] < nc_q[2]) ? 2'd0 : 2'd2;
		end else begin
			sel_ax = (nc_q[1] < nc_q[2]) ? 2'd1 : 2'd2;
		end
	end

	logic [32:0] nc_sum;
	assign nc_sum = {1'b0, nc_q[ax_q]} + {1'b0, sp_q[ax_q]};

	logic out_free;
	assign out_free = !out_valid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			extent_q    <= GRID_EXTENT_RST;
			active_q    <= 1'b0;
			nodir_q     <= 1'b0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
			sq_idx_q    <= '0;
			op_q        <= '0;
			ax_q        <= '0;
			for (int a = 0; a < 3; a++) begin
				pos_q[a]  <= '0;
				sign_q[a] <= STEP_NONE;
				nc_q[a]   <= ALL_ONES32;
				sp_q[a]   <= ALL_ONES32;
				face_q[a] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				extent_q <= cfg_wr_data;
			end
			if (out_valid_q && m_tready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						nodir_q <= 1'b0;
						for (int a = 0; a < 3; a++) begin
							face_q[a] <= '0;
						end
						if (s_tuser == CMD_START) begin
							for (int a = 0; a < 3; a++) begin
								pos_q[a]   <= st_pos[a];
								sign_q[a]  <= st_sign[a];
								mag_q[a]   <= st_mag[a];
								ncnum_q[a] <= st_ncnum[a];
							end
							len_q    <= s_tdata[139:123];
							sumsq_q  <= '0;
							sq_idx_q <= '0;
							state_q  <= ST_SQ;
						end else begin
							state_q <= ST_ADV1;
						end
					end
				end
				ST_SQ: begin
					sumsq_q <= sumsq_q + (32'(mag_q[sq_idx_q]) * 32'(mag_q[sq_idx_q]));
					if (sq_idx_q == 2'd2) begin
						op_q    <= '0;
						state_q <= ST_OP_START;
					end else begin
						sq_idx_q <= sq_idx_q + 1'b1;
					end
				end
				ST_OP_START: begin
					state_q <= ST_OP_WAIT;
				end
				ST_OP_WAIT: begin
					if (unit_done) begin
						case (op_q)
							3'd6: begin
								mq16_q  <= unit_res;
								op_q    <= op_q + 1'b1;
								state_q <= ST_OP_START;
							end
							3'd7: begin
								nodir_q  <= (sumsq_q == '0);
								limit_q  <= (sumsq_q == '0) ? '0 : unit_res;
								active_q <= (sumsq_q != '0);
								state_q  <= ST_FIN;
							end
							default: begin
								if (op_q[0]) begin
									nc_q[op_q[2:1]] <= unit_res;
								end else begin
									sp_q[op_q[2:1]] <= unit_res;
								end
								op_q    <= op_q + 1'b1;
								state_q <= ST_OP_START;
							end
						endcase
					end
				end
				ST_ADV1: begin
					active_q <= active_q && cont;
					ax_q     <= sel_ax;
					state_q  <= ST_ADV2;
				end
				ST_ADV2: begin
					if (active_q) begin
						if (nc_q[ax_q] > limit_q) begin
							active_q <= 1'b0;
						end else begin
							pos_q[ax_q]  <= pos_q[ax_q] + {{7{sign_q[ax_q][1]}}, sign_q[ax_q]};
							nc_q[ax_q]   <= nc_sum[32] ? ALL_ONES32 : nc_sum[31:0];
							face_q[ax_q] <= 2'(-sign_q[ax_q]);
						end
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						active_q    <= active_q && cont;
						out_valid_q <= 1'b1;
						out_data_q  <= {4'b0000, nodir_q, !(active_q && cont), in_grid,
						                face_q[2], face_q[1], face_q[0],
						                pos_q[2], pos_q[1], pos_q[0]};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
